>>> rtl/mi4inv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4inv_pkg: shared definitions of the 4x4 matrix inverse engine
// Default widths, the controller to datapath command word, the operand
// tables of the minors, the determinant and the cofactors.
// ----------------------------------------------------------------------------
package mi4inv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of one multiplier digit of the shared multiplier.
  localparam int MUL_CHUNK = 16;
  localparam int IDX_W     = 4;

  typedef logic [IDX_W-1:0] idx_t;

  // Phase of the computation.
  typedef enum logic [1:0] {
    MODE_MINOR,
    MODE_DET,
    MODE_COF,
    MODE_IDENT
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_we;
    idx_t ld_addr;
    idx_t rd_addr;
    logic cap_a;
    logic a_from_m;
    logic mul_init;
    logic b_from_m;
    logic mul_step;
    logic acc_en;
    logic acc_first;
    logic acc_sub;
    logic m_we;
    idx_t m_waddr;
    logic det_load;
    logic div_init;
    logic cof_neg;
    logic div_step;
    logic out_load;
    logic out_ident;
    idx_t out_index;
    logic out_sing;
    logic out_last;
  } cmd_t;

  // Operand addresses of one product term.
  typedef struct packed {
    idx_t addr_a;
    idx_t addr_b;
    logic sub;
    logic last;
  } term_t;

  // Minor k = a[p] * a[q] - a[r] * a[s].
  localparam int MINOR_TAB [12][4] = '{
    '{0, 5, 1, 4}, '{0, 6, 2, 4}, '{0, 7, 3, 4}, '{1, 6, 2, 5},
    '{1, 7, 3, 5}, '{2, 7, 3, 6}, '{8, 13, 9, 12}, '{8, 14, 10, 12},
    '{8, 15, 11, 12}, '{9, 14, 10, 13}, '{9, 15, 11, 13}, '{10, 15, 11, 14}
  };

  // Determinant terms: minor pairs and whether the term is subtracted.
  localparam int DET_TAB [6][3] = '{
    '{0, 11, 0}, '{1, 10, 1}, '{2, 9, 0}, '{3, 8, 0}, '{4, 7, 1}, '{5, 6, 0}
  };

  // Cofactor k = a[e0]*m[n0] - a[e1]*m[n1] + a[e2]*m[n2], sign by position.
  localparam int COF_TAB [16][6] = '{
    '{5, 11, 6, 10, 7, 9},  '{1, 11, 2, 10, 3, 9},
    '{13, 5, 14, 4, 15, 3}, '{9, 5, 10, 4, 11, 3},
    '{4, 11, 6, 8, 7, 7},   '{0, 11, 2, 8, 3, 7},
    '{12, 5, 14, 2, 15, 1}, '{8, 5, 10, 2, 11, 1},
    '{4, 10, 5, 8, 7, 6},   '{0, 10, 1, 8, 3, 6},
    '{12, 4, 13, 2, 15, 0}, '{8, 4, 9, 2, 11, 0},
    '{4, 9, 5, 7, 6, 6},    '{0, 9, 1, 7, 2, 6},
    '{12, 3, 13, 1, 14, 0}, '{8, 3, 9, 1, 10, 0}
  };

  // Number of multiplier digits for operands of twice the element width.
  function automatic int mul_chunks(int w);
    return (2 * w + MUL_CHUNK - 1) / MUL_CHUNK;
  endfunction

  // Operand addresses of one term of the current phase.
  function automatic term_t term_sel(mode_e mode, idx_t idx, logic [2:0] term);
    term_t t;
    int k;
    int j;
    k = int'(idx);
    j = int'(term);
    t = '0;
    case (mode)
      MODE_MINOR: begin
        if (k < 12 && j < 2) begin
          t.addr_a = idx_t'(MINOR_TAB[k][2*j]);
          t.addr_b = idx_t'(MINOR_TAB[k][2*j+1]);
        end
        t.sub  = (j == 1);
        t.last = (j >= 1);
      end
      MODE_DET: begin
        if (j < 6) begin
          t.addr_a = idx_t'(DET_TAB[j][0]);
          t.addr_b = idx_t'(DET_TAB[j][1]);
          t.sub    = DET_TAB[j][2] != 0;
        end
        t.last = (j >= 5);
      end
      MODE_COF: begin
        if (j < 3) begin
          t.addr_a = idx_t'(COF_TAB[k][2*j]);
          t.addr_b = idx_t'(COF_TAB[k][2*j+1]);
        end
        t.sub  = (j == 1);
        t.last = (j >= 2);
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/mi4inv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4inv_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mi4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mi4inv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4inv_dp: datapath of the 4x4 matrix inverse engine
// Element and minor stores, a digit-serial shared multiplier, the term
// accumulator, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module mi4inv_dp import mi4inv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  input  logic [DATA_WIDTH-1:0] element_value_i,
  output logic                  det_zero_o,
  output logic [DATA_WIDTH-1:0] result_value_o,
  output logic [3:0]            result_index_o,
  output logic                  singular_o,
  output logic                  last_element_o
);

  localparam int MW   = 2 * DATA_WIDTH;
  localparam int NCH  = mul_chunks(DATA_WIDTH);
  localparam int BW   = NCH * MUL_CHUNK;
  localparam int PW   = BW + MW;
  localparam int PPW  = MW + MUL_CHUNK;
  localparam int AW   = 4 * DATA_WIDTH + 2;
  localparam int XW_A = 5 * DATA_WIDTH + 2;
  localparam int XW_B = 3 * DATA_WIDTH + 2 * FRAC_BITS + 2;
  localparam int XW   = (XW_A > XW_B) ? XW_A : XW_B;

  localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] ONE  =
    (FRAC_BITS >= DATA_WIDTH - 1) ? MAXP : (DATA_WIDTH'(1) << FRAC_BITS);

  logic [DATA_WIDTH-1:0] a_rdata;
  logic [MW-1:0]         m_rdata;
  logic [MW-1:0]         a_ext;
  logic [MW-1:0]         a_sel;
  logic [MW-1:0]         b_sel;
  logic [MW-1:0]         b_mag;

  logic [MW-1:0]         opa_q;
  logic [MW-1:0]         ma_q;
  logic [BW-1:0]         mb_q;
  logic                  pneg_q;
  logic [PW-1:0]         p_q;
  logic [PPW-1:0]        pp;

  logic [AW-1:0]         acc_q;
  logic [AW-1:0]         p_ext;
  logic [AW-1:0]         term_val;
  logic [AW-1:0]         det_q;
  logic [AW-1:0]         cof;
  logic [AW-1:0]         dmag;

  logic [XW-1:0]         n_sh;
  logic [XW-1:0]         nmag;
  logic [XW-1:0]         d_ext;
  logic [XW-1:0]         r_q;
  logic [XW-1:0]         s_q;
  logic [DATA_WIDTH-1:0] q_q;
  logic                  ovf_q;
  logic                  qneg_q;
  logic                  ge;
  logic [DATA_WIDTH-1:0] quot_sat;
  logic [DATA_WIDTH-1:0] val_d;

  logic [DATA_WIDTH-1:0] res_value_q;
  logic [3:0]            res_index_q;
  logic                  singular_q;
  logic                  last_q;

  // Element store.
  mi4inv_ram #(.WIDTH(DATA_WIDTH), .DEPTH(16)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_we),
    .waddr_i (cmd_i.ld_addr),
    .wdata_i (element_value_i),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (a_rdata)
  );

  // Minor store.
  mi4inv_ram #(.WIDTH(MW), .DEPTH(12)) u_minor_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.m_we),
    .waddr_i (cmd_i.m_waddr),
    .wdata_i (acc_q[MW-1:0]),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (m_rdata)
  );

  // Operand selection with sign extension of elements.
  always_comb begin
    a_ext = {{(MW-DATA_WIDTH){a_rdata[DATA_WIDTH-1]}}, a_rdata};
    a_sel = cmd_i.a_from_m ? m_rdata : a_ext;
    b_sel = cmd_i.b_from_m ? m_rdata : a_ext;
    b_mag = b_sel[MW-1] ? -b_sel : b_sel;
  end

  // One partial product of the digit-serial multiplier.
  assign pp = PPW'(ma_q) * PPW'(mb_q[BW-1 -: MUL_CHUNK]);

  // Multiplier: magnitudes, most significant digit first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      opa_q <= a_sel;
    end
    if (cmd_i.mul_init) begin
      ma_q   <= opa_q[MW-1] ? -opa_q : opa_q;
      mb_q   <= BW'(b_mag);
      pneg_q <= opa_q[MW-1] ^ b_sel[MW-1];
      p_q    <= '0;
    end else if (cmd_i.mul_step) begin
      p_q  <= (p_q << MUL_CHUNK) + PW'(pp);
      mb_q <= mb_q << MUL_CHUNK;
    end
  end

  // Signed term added to or subtracted from the accumulator.
  always_comb begin
    p_ext    = AW'(p_q);
    term_val = (pneg_q ^ cmd_i.acc_sub) ? -p_ext : p_ext;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q <= (cmd_i.acc_first ? '0 : acc_q) + term_val;
    end
    if (cmd_i.det_load) begin
      det_q <= acc_q;
    end
  end

  assign det_zero_o = (det_q == '0);

  // Divider operands: scaled cofactor magnitude and determinant magnitude.
  always_comb begin
    cof   = cmd_i.cof_neg ? -acc_q : acc_q;
    n_sh  = {{(XW-AW){cof[AW-1]}}, cof} << (2 * FRAC_BITS);
    nmag  = n_sh[XW-1] ? -n_sh : n_sh;
    dmag  = det_q[AW-1] ? -det_q : det_q;
    d_ext = XW'(dmag);
    ge    = (r_q >= s_q);
  end

  // Restoring division, one quotient bit per step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      r_q    <= nmag;
      s_q    <= d_ext << (DATA_WIDTH - 1);
      q_q    <= '0;
      ovf_q  <= (nmag >= (d_ext << DATA_WIDTH));
      qneg_q <= cof[AW-1] ^ det_q[AW-1];
    end else if (cmd_i.div_step) begin
      r_q <= ge ? (r_q - s_q) : r_q;
      s_q <= s_q >> 1;
      q_q <= {q_q[DATA_WIDTH-2:0], ge};
    end
  end

  // Saturation of the quotient and the identity fallback.
  always_comb begin
    if (qneg_q) begin
      quot_sat = (ovf_q || (q_q > MINV)) ? MINV : -q_q;
    end else begin
      quot_sat = (ovf_q || q_q[DATA_WIDTH-1]) ? MAXP : q_q;
    end
    if (cmd_i.out_ident) begin
      val_d = (cmd_i.out_index[1:0] == cmd_i.out_index[3:2]) ? ONE : '0;
    end else begin
      val_d = quot_sat;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_value_q <= val_d;
      res_index_q <= cmd_i.out_index;
      singular_q  <= cmd_i.out_sing;
      last_q      <= cmd_i.out_last;
    end
  end

  assign result_value_o = res_value_q;
  assign result_index_o = res_index_q;
  assign singular_o     = singular_q;
  assign last_element_o = last_q;

endmodule

>>> rtl/mi4inv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4inv_ctrl: controller of the 4x4 matrix inverse engine
// Sequences loading, the minor, determinant and cofactor products, the
// divisions and the hand-off of each result word.
// ----------------------------------------------------------------------------
module mi4inv_ctrl import mi4inv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic det_zero_i,
  output cmd_t cmd_o
);

  localparam int NCH = mul_chunks(DATA_WIDTH);
  localparam int CW  = $clog2(DATA_WIDTH + 1);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b00_0000_0001,
    S_RDA   = 10'b00_0000_0010,
    S_RDB   = 10'b00_0000_0100,
    S_LDB   = 10'b00_0000_1000,
    S_MUL   = 10'b00_0001_0000,
    S_ACC   = 10'b00_0010_0000,
    S_STORE = 10'b00_0100_0000,
    S_CHK   = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e        state_q, state_d;
  mode_e         mode_q, mode_d;
  idx_t          idx_q, idx_d;
  idx_t          load_q, load_d;
  logic [2:0]    term_q, term_d;
  logic [CW-1:0] cyc_q, cyc_d;
  logic          out_valid_q, out_valid_d;
  term_t         term;

  assign term = term_sel(mode_q, idx_q, term_q);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    idx_d   = idx_q;
    load_d  = load_q;
    term_d  = term_q;
    cyc_d   = cyc_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.ld_we   = 1'b1;
          cmd_o.ld_addr = load_q;
          load_d        = load_q + idx_t'(1);
          if (load_q == idx_t'(15)) begin
            state_d = S_RDA;
            mode_d  = MODE_MINOR;
            idx_d   = '0;
            term_d  = '0;
          end
        end
      end
      S_RDA: begin
        cmd_o.rd_addr = term.addr_a;
        state_d       = S_RDB;
      end
      S_RDB: begin
        cmd_o.cap_a    = 1'b1;
        cmd_o.a_from_m = (mode_q == MODE_DET);
        cmd_o.rd_addr  = term.addr_b;
        state_d        = S_LDB;
      end
      S_LDB: begin
        cmd_o.mul_init = 1'b1;
        cmd_o.b_from_m = (mode_q != MODE_MINOR);
        cyc_d          = '0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cyc_d          = cyc_q + CW'(1);
        if (cyc_q == CW'(NCH - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_first = (term_q == 3'd0);
        cmd_o.acc_sub   = term.sub;
        if (term.last) begin
          term_d  = '0;
          state_d = S_STORE;
        end else begin
          term_d  = term_q + 3'd1;
          state_d = S_RDA;
        end
      end
      S_STORE: begin
        case (mode_q)
          MODE_MINOR: begin
            cmd_o.m_we    = 1'b1;
            cmd_o.m_waddr = idx_q;
            state_d       = S_RDA;
            if (idx_q == idx_t'(11)) begin
              mode_d = MODE_DET;
              idx_d  = '0;
            end else begin
              idx_d = idx_q + idx_t'(1);
            end
          end
          MODE_DET: begin
            cmd_o.det_load = 1'b1;
            state_d        = S_CHK;
          end
          MODE_COF: begin
            cmd_o.div_init = 1'b1;
            cmd_o.cof_neg  = idx_q[2] ^ idx_q[0];
            cyc_d          = '0;
            state_d        = S_DIV;
          end
          default: state_d = S_LOAD;
        endcase
      end
      S_CHK: begin
        idx_d = '0;
        if (det_zero_i) begin
          mode_d  = MODE_IDENT;
          state_d = S_OUT;
        end else begin
          mode_d  = MODE_COF;
          state_d = S_RDA;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cyc_d          = cyc_q + CW'(1);
        if (cyc_q == CW'(DATA_WIDTH - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_ident = (mode_q == MODE_IDENT);
          cmd_o.out_index = idx_q;
          cmd_o.out_sing  = (mode_q == MODE_IDENT);
          cmd_o.out_last  = (idx_q == idx_t'(15));
          if (idx_q == idx_t'(15)) begin
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + idx_t'(1);
            state_d = (mode_q == MODE_IDENT) ? S_OUT : S_RDA;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Result word valid flag.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      mode_q      <= MODE_MINOR;
      idx_q       <= '0;
      load_q      <= '0;
      term_q      <= '0;
      cyc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      load_q      <= load_d;
      term_q      <= term_d;
      cyc_q       <= cyc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A new result word never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten while stalled");

  // After the last word of a matrix the block loads again.
  a_last_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (state_q == S_LOAD))
    else $error("no return to loading after last word");

  // Divisions start only in the cofactor phase.
  a_div_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_init |-> (mode_q == MODE_COF))
    else $error("division started outside cofactor phase");
`endif

endmodule

>>> rtl/matrix4_inverse_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_inverse_engine: 4x4 fixed-point matrix inverse, adjugate method
// Input channel: sixteen element words per matrix, column-major, signed
// Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS. Output channel: sixteen inverse words,
// column-major, each with its index, a singular flag and a last flag.
// Loading takes each word that in_valid_i presents. After the sixteenth word
// the block stops taking input and works through one shared digit-serial
// multiplier (NCH = ceil(2*DATA_WIDTH/16) digits of 16 bits per operand)
// and a restoring divider (one quotient bit per cycle). A singular matrix
// skips the cofactors and divisions after the determinant. The multiplier
// and divider set the compute time.
// Results leave through an output register: a stalled receiver holds the
// waiting word and the sequencer pauses before the next one. After the last
// word is registered the block takes the next matrix at once.
// Reset clears the control state and the load count; the stores need none.
// ----------------------------------------------------------------------------
module matrix4_inverse_engine import mi4inv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] element_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] result_value_o,
  output logic [3:0]            result_index_o,
  output logic                  singular_o,
  output logic                  last_element_o
);

  cmd_t cmd;
  logic det_zero;

  // Sequencer.
  mi4inv_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .det_zero_i  (det_zero),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  mi4inv_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .element_value_i (element_value_i),
    .det_zero_o      (det_zero),
    .result_value_o  (result_value_o),
    .result_index_o  (result_index_o),
    .singular_o      (singular_o),
    .last_element_o  (last_element_o)
  );

endmodule
